FILE: sv/cell_grid_neighbor_check_assert.svh
// assertion macros used by the checker file
`ifndef CELL_GRID_NEIGHBOR_CHECK_ASSERT_SVH
`define CELL_GRID_NEIGHBOR_CHECK_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define CGNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define CGNC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cgnc_pkg.sv
`default_nettype none

package cgnc_pkg;

    // fixed field widths
    localparam int POS_W  = 24;
    localparam int CLEN_W = 23;
    localparam int CNT_W  = 5;

    // packed stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // cell length after reset, 1.0 in unsigned q15.8
    localparam logic [CLEN_W-1:0] CLEN_RESET = 23'd256;

    // last step of the bit-serial divider
    localparam logic [CNT_W-1:0] DIV_LAST = 5'(POS_W - 1);

    // operation codes carried in tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // neighbor offset codes per axis
    localparam logic [1:0] OFS_LOW  = 2'd0;
    localparam logic [1:0] OFS_MID  = 2'd1;
    localparam logic [1:0] OFS_HIGH = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FIX,
        S_ADD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/cell_grid_neighbor_check.sv
`default_nettype none

// Cell grid neighbor check: each item either marks the cell of a q16.8 position as occupied
// (operation 0) or asks whether that cell or any of its 3^DIMS-1 neighbors is occupied
// (operation 1); exactly one result item comes back per input item. Cell indexes are
// floor(coordinate / cell edge length), computed by one restoring divider that retires one
// quotient bit per cycle and is shared by all axes. A query then reads the occupancy memory
// once per neighbor cell through its single read port. The result shows in the same cycle
// that the next item can be taken; a stalled result keeps the block waiting on it. Input
// ready is low while an item is at work. After reset a clearing pass writes every one of
// the CELLS_PER_AXIS^DIMS cells before the first item is taken; the cell length register
// may be written meanwhile and is read throughout every division.
module cell_grid_neighbor_check #(
    parameter int DIMS           = 3,
    parameter int CELLS_PER_AXIS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input items
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    input  wire  [cgnc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // operation [0]
    input  wire                             i_s_axis_tuser,
    // result items
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // neighbor_found [0], out_of_grid [1], zero fill [7:2]
    output logic [cgnc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // cell length register write
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [cgnc_pkg::CLEN_W-1:0]     i_cfg_data
);

    localparam int AXW        = $clog2(CELLS_PER_AXIS);
    localparam int CELL_COUNT = CELLS_PER_AXIS ** DIMS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PLANE      = CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int PW         = cgnc_pkg::POS_W;
    localparam int NB_W       = PW + 1;
    localparam logic [1:0]        LAST_AXIS = 2'(DIMS - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(CELL_COUNT - 1);

    // control registers
    cgnc_pkg::t_state            r_state, n_state;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic [cgnc_pkg::CLEN_W-1:0] r_clen;
    logic                        r_out_vld;
    logic                        r_rd_vld;

    // payload registers
    logic [PW-1:0]               r_pos [0:2];
    logic [PW-1:0]               r_ctr [0:2];
    logic                        r_op;
    logic [1:0]                  r_axis;
    logic [PW-1:0]               r_quo, n_quo;
    logic [cgnc_pkg::CLEN_W-1:0] r_rem, n_rem;
    logic                        r_neg;
    logic [cgnc_pkg::CNT_W-1:0]  r_cnt;
    logic [1:0]                  r_ox, r_oy, r_oz;
    logic                        r_found;
    logic                        r_out_found;
    logic                        r_out_oog;
    logic                        r_rd_data;
    logic                        r_occ [0:CELL_COUNT-1];

    // combinational
    logic                        s_acc;
    logic                        out_load;
    logic                        scan_issue;
    logic                        scan_last;
    logic                        mem_we;
    logic                        mem_wdata;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           ctr_addr;
    logic [cgnc_pkg::CLEN_W-1:0] clen_eff;
    logic [PW-1:0]               div_shift;
    logic [PW:0]                 div_diff;
    logic                        div_ge;
    logic [NB_W-1:0]             q_plus;
    logic [PW-1:0]               ctr_fix;
    logic                        ctr_in_grid;
    logic [NB_W-1:0]             nx, ny, nz;
    logic                        nb_in;
    logic                        found_now;
    logic [1:0]                  axis_nxt;

    // magnitude of a signed coordinate, fits unsigned
    function automatic logic [PW-1:0] abs_pos(input logic [PW-1:0] p);
        abs_pos = p[PW-1] ? (~p + PW'(1)) : p;
    endfunction

    // one axis index inside 0..CELLS_PER_AXIS-1
    function automatic logic axis_in(input logic [NB_W-1:0] v);
        axis_in = !v[NB_W-1] && (v[NB_W-2:0] < (NB_W-1)'(CELLS_PER_AXIS));
    endfunction

    // linear cell address x + C*(y + C*z)
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [AXW-1:0] x,
                                                   input logic [AXW-1:0] y,
                                                   input logic [AXW-1:0] z);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(x) + ADDR_W'(CELLS_PER_AXIS) * ADDR_W'(y);
        if (DIMS == 3) begin
            a = a + ADDR_W'(PLANE) * ADDR_W'(z);
        end
        cell_addr = a;
    endfunction

    assign s_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign clen_eff    = (r_clen == '0) ? cgnc_pkg::CLEN_W'(1) : r_clen;
    assign axis_nxt    = r_axis + 2'd1;

    // restoring divider step, one quotient bit
    assign div_shift = {r_rem, r_quo[PW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b0, clen_eff};
    assign div_ge    = !div_diff[PW];
    assign n_rem     = div_ge ? div_diff[cgnc_pkg::CLEN_W-1:0]
                              : div_shift[cgnc_pkg::CLEN_W-1:0];
    assign n_quo     = {r_quo[PW-2:0], div_ge};

    // floor correction for negative coordinates
    assign q_plus  = {1'b0, r_quo} + NB_W'(r_rem != '0);
    assign ctr_fix = r_neg ? (~q_plus[PW-1:0] + PW'(1)) : r_quo;

    // own cell
    assign ctr_in_grid = axis_in({r_ctr[0][PW-1], r_ctr[0]})
                      && axis_in({r_ctr[1][PW-1], r_ctr[1]})
                      && ((DIMS == 2) || axis_in({r_ctr[2][PW-1], r_ctr[2]}));
    assign ctr_addr = cell_addr(r_ctr[0][AXW-1:0], r_ctr[1][AXW-1:0], r_ctr[2][AXW-1:0]);

    // neighbor cell under scan
    assign nx = {r_ctr[0][PW-1], r_ctr[0]} + NB_W'(r_ox) - NB_W'(1);
    assign ny = {r_ctr[1][PW-1], r_ctr[1]} + NB_W'(r_oy) - NB_W'(1);
    assign nz = {r_ctr[2][PW-1], r_ctr[2]} + NB_W'(r_oz) - NB_W'(1);
    assign nb_in = axis_in(nx) && axis_in(ny) && ((DIMS == 2) || axis_in(nz));
    assign rd_addr = nb_in ? cell_addr(nx[AXW-1:0], ny[AXW-1:0], nz[AXW-1:0]) : '0;
    assign scan_last = (r_ox == cgnc_pkg::OFS_HIGH) && (r_oy == cgnc_pkg::OFS_HIGH)
                    && ((DIMS == 2) || (r_oz == cgnc_pkg::OFS_HIGH));

    assign found_now = r_found || (r_rd_vld && r_rd_data);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cgnc_pkg::S_CLEAR: if (r_clr_addr == CLR_LAST) n_state = cgnc_pkg::S_IDLE;
            cgnc_pkg::S_IDLE:  if (s_acc) n_state = cgnc_pkg::S_DIV;
            cgnc_pkg::S_DIV:   if (r_cnt == cgnc_pkg::DIV_LAST) n_state = cgnc_pkg::S_FIX;
            cgnc_pkg::S_FIX: begin
                if (r_axis != LAST_AXIS) begin
                    n_state = cgnc_pkg::S_DIV;
                end else if (r_op == cgnc_pkg::OP_QUERY) begin
                    n_state = cgnc_pkg::S_SCAN;
                end else begin
                    n_state = cgnc_pkg::S_ADD;
                end
            end
            cgnc_pkg::S_ADD:   n_state = cgnc_pkg::S_DONE;
            cgnc_pkg::S_SCAN:  if (scan_last) n_state = cgnc_pkg::S_DONE;
            cgnc_pkg::S_DONE:  if (out_load) n_state = cgnc_pkg::S_IDLE;
            default:           n_state = cgnc_pkg::S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = 1'b0;
        mem_waddr       = ctr_addr;
        scan_issue      = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            cgnc_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            cgnc_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            cgnc_pkg::S_ADD: begin
                mem_we    = ctr_in_grid;
                mem_wdata = 1'b1;
            end
            cgnc_pkg::S_SCAN: scan_issue = nb_in;
            cgnc_pkg::S_DONE: out_load = !r_out_vld || i_m_axis_tready;
            cgnc_pkg::S_DIV, cgnc_pkg::S_FIX: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cgnc_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_clen     <= cgnc_pkg::CLEN_RESET;
            r_out_vld  <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue;
            if (r_state == cgnc_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_clen <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // division, index and scan datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cgnc_pkg::S_IDLE: begin
                if (s_acc) begin
                    r_pos[0] <= i_s_axis_tdata[PW-1:0];
                    r_pos[1] <= i_s_axis_tdata[2*PW-1:PW];
                    r_pos[2] <= i_s_axis_tdata[3*PW-1:2*PW];
                    r_op     <= i_s_axis_tuser;
                    r_axis   <= 2'd0;
                    r_quo    <= abs_pos(i_s_axis_tdata[PW-1:0]);
                    r_neg    <= i_s_axis_tdata[PW-1];
                    r_rem    <= '0;
                    r_cnt    <= '0;
                end
            end
            cgnc_pkg::S_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + cgnc_pkg::CNT_W'(1);
            end
            cgnc_pkg::S_FIX: begin
                r_ctr[r_axis] <= ctr_fix;
                if (r_axis != LAST_AXIS) begin
                    r_axis <= axis_nxt;
                    r_quo  <= abs_pos(r_pos[axis_nxt]);
                    r_neg  <= r_pos[axis_nxt][PW-1];
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
                r_ox <= cgnc_pkg::OFS_LOW;
                r_oy <= cgnc_pkg::OFS_LOW;
                r_oz <= (DIMS == 3) ? cgnc_pkg::OFS_LOW : cgnc_pkg::OFS_MID;
            end
            cgnc_pkg::S_SCAN: begin
                if (r_ox != cgnc_pkg::OFS_HIGH) begin
                    r_ox <= r_ox + 2'd1;
                end else begin
                    r_ox <= cgnc_pkg::OFS_LOW;
                    if (r_oy != cgnc_pkg::OFS_HIGH) begin
                        r_oy <= r_oy + 2'd1;
                    end else begin
                        r_oy <= cgnc_pkg::OFS_LOW;
                        r_oz <= r_oz + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // hit accumulation over the scan
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_found <= 1'b0;
        end else begin
            r_found <= found_now;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= found_now;
            r_out_oog   <= !ctr_in_grid;
        end
    end

    // occupancy memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_occ[rd_addr];
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(cgnc_pkg::M_TDATA_W-2)'(0), r_out_oog, r_out_found};

endmodule

`default_nettype wire

FILE: sv/cgnc_checker.sv
`default_nettype none

`include "cell_grid_neighbor_check_assert.svh"

module cgnc_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_s_axis_tvalid,
    input wire                            o_s_axis_tready,
    input wire                            o_m_axis_tvalid,
    input wire                            i_m_axis_tready,
    input wire [cgnc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    // a stalled result stays offered
    `CGNC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")

    // a stalled result keeps its bits
    `CGNC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "result changed while stalled")

    // one item at work at a time
    `CGNC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready right after an accepted item")

    // a new result only comes out of a busy cycle
    `CGNC_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready), "result appeared without work in progress")

endmodule

bind cell_grid_neighbor_check cgnc_checker u_cgnc_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // raw signed q16.8 coordinate
    typedef logic signed [cgnc_pkg::POS_W-1:0] t_coord;

    typedef struct packed {
        logic found;
        logic outside;
    } t_cell_result;

    // grid shape of the instance under test
    localparam int AXIS_CELLS = 16;
    localparam int GRID_CELLS = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;

    // result bit positions in the master tdata
    localparam int FOUND_BIT = 0;
    localparam int OUTSIDE_BIT = 1;

    // signed q16.8 coordinate limits
    localparam longint POS_MAX = 64'sd8388607;
    localparam longint POS_MIN = -64'sd8388608;
    localparam t_coord COORD_MAX = t_coord'(POS_MAX);
    localparam t_coord COORD_MIN = t_coord'(POS_MIN);

    // cell length extremes
    localparam logic [cgnc_pkg::CLEN_W-1:0] CLEN_MAX = '1;
    localparam logic [cgnc_pkg::CLEN_W-1:0] CLEN_ZERO = '0;
    localparam logic [cgnc_pkg::CLEN_W-1:0] CLEN_ONE = 23'd1;

    // cycles without any handshake before giving up (clearing pass included)
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;

    // random traffic shape
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 156;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic                           s_tvalid = 1'b0;
    logic [cgnc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tuser = cgnc_pkg::OP_ADD;
    logic                           m_tready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [cgnc_pkg::CLEN_W-1:0]    cfg_data = '0;

    // block outputs
    logic                           s_tready;
    logic                           m_tvalid;
    logic [cgnc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_ready;

    // predictor state
    t_cell_result                   expected_results[$];
    bit                             grid_occupied[GRID_CELLS];
    logic [cgnc_pkg::CLEN_W-1:0]    grid_cell_len = cgnc_pkg::CLEN_RESET;

    int                             err_count = 0;
    int                             result_count = 0;
    bit                             idle_enable = 1'b1;
    int                             stall_left = 0;
    int                             quiet_cycles = 0;

    cell_grid_neighbor_check #(
        .DIMS(3),
        .CELLS_PER_AXIS(AXIS_CELLS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    // print one mismatch line and count it
    task automatic report_mismatch(string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, result_count, what);
        err_count++;
    endtask

    // floor division of a raw q16.8 coordinate by the cell length
    function automatic longint floor_cell(t_coord pos, longint len);
        longint p;
        p = longint'(pos);
        if (p >= 0) begin
            return p / len;
        end
        return -((-p + len - 1) / len);
    endfunction

    function automatic bit cell_in_grid(longint cx, longint cy, longint cz);
        return cx >= 0 && cx < AXIS_CELLS && cy >= 0 && cy < AXIS_CELLS
            && cz >= 0 && cz < AXIS_CELLS;
    endfunction

    function automatic int cell_addr(longint cx, longint cy, longint cz);
        return int'(cx + AXIS_CELLS * (cy + AXIS_CELLS * cz));
    endfunction

    // update the occupancy copy and queue the result one item must give
    task automatic predict_cell_result(logic op, t_coord px, t_coord py, t_coord pz);
        longint len;
        longint cx;
        longint cy;
        longint cz;
        t_cell_result res;
        len = (grid_cell_len == CLEN_ZERO) ? 1 : longint'(grid_cell_len);
        cx = floor_cell(px, len);
        cy = floor_cell(py, len);
        cz = floor_cell(pz, len);
        res.outside = !cell_in_grid(cx, cy, cz);
        res.found = 1'b0;
        if (op == cgnc_pkg::OP_ADD) begin
            if (!res.outside) begin
                grid_occupied[cell_addr(cx, cy, cz)] = 1'b1;
            end
        end else begin
            // own cell and all 26 neighbors, cells off the grid read as empty
            for (longint dz = -1; dz <= 1; dz++) begin
                for (longint dy = -1; dy <= 1; dy++) begin
                    for (longint dx = -1; dx <= 1; dx++) begin
                        if (cell_in_grid(cx + dx, cy + dy, cz + dz)) begin
                            if (grid_occupied[cell_addr(cx + dx, cy + dy, cz + dz)]) begin
                                res.found = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        expected_results.insert(expected_results.size(), res);
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(logic op, t_coord px, t_coord py, t_coord pz);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {pz, py, px};
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        predict_cell_result(op, px, py, pz);
    endtask

    // drop valid and hold it low for the requested pause
    task automatic pause_input(int cycles);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (idle_enable && $urandom_range(3) == 0) begin
            pause_input($urandom_range(1, 5));
        end
    endtask

    // stop offering items and wait for every pending result
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // write the cell length while the block is idle
    task automatic write_cell_edge(logic [cgnc_pkg::CLEN_W-1:0] len);
        wait_results_drained();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        grid_cell_len = len;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // coordinate in cell idx at the current length, clamped to the field range
    function automatic t_coord coord_for(longint idx, longint ofs);
        longint len;
        longint v;
        len = (grid_cell_len == CLEN_ZERO) ? 1 : longint'(grid_cell_len);
        v = idx * len + ofs;
        if (v > POS_MAX) v = POS_MAX;
        if (v < POS_MIN) v = POS_MIN;
        return v[cgnc_pkg::POS_W-1:0];
    endfunction

    // random coordinate: mostly near the grid, sometimes any raw value
    function automatic t_coord random_coord(int lo, int hi);
        longint len;
        longint idx;
        if ($urandom_range(9) == 0) begin
            return t_coord'($urandom());
        end
        len = (grid_cell_len == CLEN_ZERO) ? 1 : longint'(grid_cell_len);
        idx = longint'($urandom_range(hi - lo)) + lo;
        return coord_for(idx, longint'($urandom_range(int'(len - 1))));
    endfunction

    // empty grid, own cell, diagonal neighbor, repeated add, fractional positions
    task automatic test_basic_cells();
        send_item(cgnc_pkg::OP_QUERY, coord_for(0, 0), coord_for(0, 0), coord_for(0, 0));
        send_item(cgnc_pkg::OP_ADD, coord_for(0, 0), coord_for(0, 0), coord_for(0, 0));
        send_item(cgnc_pkg::OP_ADD, coord_for(0, 17), coord_for(0, 3), coord_for(0, 200));
        send_item(cgnc_pkg::OP_QUERY, coord_for(0, 255), coord_for(0, 255), coord_for(0, 255));
        send_item(cgnc_pkg::OP_QUERY, coord_for(1, 0), coord_for(1, 0), coord_for(1, 0));
        send_item(cgnc_pkg::OP_QUERY, coord_for(2, 0), coord_for(1, 0), coord_for(1, 0));
        send_item(cgnc_pkg::OP_ADD, coord_for(5, 128), coord_for(6, 1), coord_for(7, 255));
        send_item(cgnc_pkg::OP_QUERY, coord_for(6, 0), coord_for(7, 0), coord_for(8, 0));
        send_item(cgnc_pkg::OP_QUERY, coord_for(5, 0), coord_for(6, 0), coord_for(9, 0));
        wait_results_drained();
    endtask

    // adds dropped off the grid, queries at and beyond the edges, extreme values
    task automatic test_grid_edges();
        send_item(cgnc_pkg::OP_ADD, coord_for(0, -1), coord_for(0, -1), coord_for(0, -1));
        send_item(cgnc_pkg::OP_QUERY, coord_for(0, -1), coord_for(0, -1), coord_for(0, -1));
        send_item(cgnc_pkg::OP_ADD, coord_for(15, 255), coord_for(15, 255), coord_for(15, 255));
        send_item(cgnc_pkg::OP_QUERY, coord_for(16, 0), coord_for(16, 0), coord_for(16, 0));
        send_item(cgnc_pkg::OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(cgnc_pkg::OP_ADD, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(cgnc_pkg::OP_QUERY, COORD_MAX, COORD_MIN, COORD_MAX);
        send_item(cgnc_pkg::OP_QUERY, coord_for(15, 0), coord_for(0, 0), coord_for(16, 0));
        send_item(cgnc_pkg::OP_QUERY, coord_for(-1, -1), coord_for(3, 0), coord_for(3, 0));
        wait_results_drained();
    endtask

    // smallest, zero and largest cell length
    task automatic test_edge_lengths();
        write_cell_edge(CLEN_ONE);
        send_item(cgnc_pkg::OP_ADD, coord_for(3, 0), coord_for(3, 0), coord_for(3, 0));
        send_item(cgnc_pkg::OP_QUERY, coord_for(4, 0), coord_for(4, 0), coord_for(4, 0));
        write_cell_edge(CLEN_ZERO);
        send_item(cgnc_pkg::OP_QUERY, coord_for(2, 0), coord_for(2, 0), coord_for(2, 0));
        send_item(cgnc_pkg::OP_ADD, coord_for(16, 0), coord_for(0, 0), coord_for(0, 0));
        write_cell_edge(CLEN_MAX);
        send_item(cgnc_pkg::OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(cgnc_pkg::OP_QUERY, coord_for(0, -1), coord_for(0, 0), coord_for(0, 0));
        wait_results_drained();
    endtask

    // phases of random adds and queries, one cell length per phase
    task automatic test_random_traffic();
        logic [cgnc_pkg::CLEN_W-1:0] lengths[RANDOM_PHASES];
        logic op;
        int z_hi;
        lengths[0] = cgnc_pkg::CLEN_RESET;
        lengths[1] = CLEN_ONE;
        lengths[2] = 23'd4096;
        lengths[3] = cgnc_pkg::CLEN_W'($urandom_range(2, 1000));
        lengths[4] = cgnc_pkg::CLEN_W'($urandom_range(100000, 8388606));
        lengths[5] = CLEN_MAX;
        lengths[6] = CLEN_ZERO;
        lengths[7] = 23'd640;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_cell_edge(lengths[ph]);
            // the last phase runs with no idling on either side
            idle_enable = (ph != RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(99) < 35) ? cgnc_pkg::OP_ADD : cgnc_pkg::OP_QUERY;
                // adds stay in the low layers so high queries can come back empty
                z_hi = (op == cgnc_pkg::OP_ADD) ? 4 : AXIS_CELLS;
                maybe_gap();
                send_item(op, random_coord(-1, AXIS_CELLS), random_coord(-1, AXIS_CELLS),
                          random_coord(-1, z_hi));
            end
        end
        wait_results_drained();
    endtask

    // result side ready with random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_enable && $urandom_range(5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[FOUND_BIT] !== want.found) begin
                    report_mismatch($sformatf("neighbor_found %b, predicted %b",
                                              m_tdata[FOUND_BIT], want.found));
                end
                if (m_tdata[OUTSIDE_BIT] !== want.outside) begin
                    report_mismatch($sformatf("out_of_grid %b, predicted %b",
                                              m_tdata[OUTSIDE_BIT], want.outside));
                end
            end
            result_count++;
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[cell_grid_neighbor_check] ERROR");
            $finish;
        end
    end

    // reset once, then the tests in turn
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_cells();
        test_grid_edges();
        test_edge_lengths();
        test_random_traffic();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[cell_grid_neighbor_check] OK");
        end else begin
            $display("[cell_grid_neighbor_check] ERROR");
        end
        $finish;
    end

endmodule
